@@ design/sfa_pkg.sv @@
package sfa_pkg;

    // command codes
    localparam logic [3:0] CMD_PACK   = 4'd0;
    localparam logic [3:0] CMD_UNPACK = 4'd1;
    localparam logic [3:0] CMD_ADD    = 4'd2;
    localparam logic [3:0] CMD_SUB    = 4'd3;
    localparam logic [3:0] CMD_MUL    = 4'd4;
    localparam logic [3:0] CMD_DIV    = 4'd5;
    localparam logic [3:0] CMD_EQ     = 4'd6;
    localparam logic [3:0] CMD_GE     = 4'd7;
    localparam logic [3:0] CMD_GT     = 4'd8;
    localparam logic [3:0] CMD_LE     = 4'd9;
    localparam logic [3:0] CMD_LT     = 4'd10;

    // quotient bits produced by the divider, one per stage
    localparam int DIV_STEPS = 26;

    // everything one transaction carries down the pipeline
    typedef struct packed {
        logic [3:0]        cmd;
        logic              rf;
        logic              raw_eq;
        logic [31:0]       fa;
        logic [31:0]       fb;
        logic              cmp;
        logic              spec_zero;
        logic              spec_ovf;
        logic              eff_sub;
        logic              sgn;
        logic signed [9:0] expo;
        logic [47:0]       wide;
        logic [27:0]       x;
        logic [27:0]       xs;
        logic [7:0]        shamt;
        logic [4:0]        lz;
        logic [24:0]       drem;
        logic [25:0]       dq;
        logic [23:0]       dd;
    } t_stage;

endpackage

@@ design/short_float_alu.sv @@
// short_float_alu: 16-bit short-float unit (1 sign, 15-MANT_BITS exponent, MANT_BITS mantissa
// bits, exponent offset 127 - 2^(15-MANT_BITS)/2 from float32). Each transaction carries one
// command: pack a float32, unpack a code, add, subtract, multiply, divide or compare. Arithmetic
// is float32 with round-to-nearest-even, then packed by truncating the mantissa; results out of
// the packable range give code 0, with o_pack_overflow set when the exponent is too large or the
// value is infinity or NaN. The pipeline takes one transaction per cycle while not stalled, and
// every transaction comes out in order; the divider produces one quotient bit per stage over 26
// stages, and all commands travel the same path. While o_valid is high and i_stall holds the
// result, the whole pipeline freezes and o_stall is raised; nothing is lost or repeated.
module short_float_alu #(
    parameter int MANT_BITS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_command,
    input  logic [15:0] i_left_code,
    input  logic [31:0] i_right_value,
    input  logic        i_right_is_float,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result_code,
    output logic [31:0] o_result_float,
    output logic        o_compare_true,
    output logic        o_pack_overflow
);
    import sfa_pkg::*;

    localparam int EXP_BITS   = 15 - MANT_BITS;
    localparam int EXP_RANGE  = 1 << EXP_BITS;
    localparam int BIAS_FLOOR = 127 - (EXP_RANGE / 2);
    localparam int SHIFT      = 23 - MANT_BITS;

    // code to float32 bits; code zero deliberately decodes to the smallest exponent
    function automatic logic [31:0] f_decode(input logic [15:0] code);
        logic [7:0] e;
        e = 8'(32'(code[14:MANT_BITS]) + 32'(BIAS_FLOOR));
        return {code[15], e, code[MANT_BITS-1:0], {SHIFT{1'b0}}};
    endfunction

    // float fields to {overflow, code}; mantissa is truncated
    function automatic logic [16:0] f_encode(input logic sgn, input logic signed [9:0] ex,
                                             input logic [22:0] m);
        logic signed [10:0] e2;
        e2 = 11'(ex) - 11'(BIAS_FLOOR);
        if (e2 < 11'sd0) begin
            return 17'd0;
        end else if (e2 >= 11'(EXP_RANGE)) begin
            return {1'b1, 16'd0};
        end else begin
            return {1'b0, sgn, e2[EXP_BITS-1:0], m[22 -: MANT_BITS]};
        end
    endfunction

    // global advance: the pipeline moves unless a finished result is held
    logic w_en;
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    logic   r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    t_stage r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7;
    t_stage n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7;

    logic   w_dv [0:DIV_STEPS];
    t_stage w_ds [0:DIV_STEPS];

    logic        r_out_valid;
    logic [15:0] r_out_code;
    logic [31:0] r_out_float;
    logic        r_out_cmp;
    logic        r_out_ovf;
    logic [15:0] n_out_code;
    logic [31:0] n_out_float;
    logic        n_out_cmp;
    logic        n_out_ovf;

    // stage 1: capture and decode operands; pack always reads the raw float32
    always_comb begin
        n_s1        = '0;
        n_s1.cmd    = i_command;
        n_s1.rf     = i_right_is_float;
        n_s1.raw_eq = (i_left_code == i_right_value[15:0]);
        n_s1.fa     = f_decode(i_left_code);
        n_s1.fb     = (i_command == CMD_PACK || i_right_is_float) ? i_right_value
                                                                   : f_decode(i_right_value[15:0]);
    end

    // stage 2: classify, compare, multiply, order add operands, set up divide
    always_comb begin
        logic [7:0]  ea, eb, ebe;
        logic [23:0] ma, mb, mbe;
        logic        b_nan, sbe, a_big;
        logic [31:0] ka, kb;
        logic        lt, gt;
        ea    = r_s1.fa[30:23];
        eb    = r_s1.fb[30:23];
        ma    = {1'b1, r_s1.fa[22:0]};
        mb    = {1'b1, r_s1.fb[22:0]};
        b_nan = (eb == 8'hFF) && (r_s1.fb[22:0] != 23'd0);
        ka    = r_s1.fa[31] ? ~r_s1.fa : (r_s1.fa | 32'h8000_0000);
        kb    = r_s1.fb[31] ? ~r_s1.fb : (r_s1.fb | 32'h8000_0000);
        lt    = ka < kb;
        gt    = ka > kb;
        // denormal b is far below half an ulp of any decoded a, so it adds as zero
        ebe   = (eb == 8'd0) ? 8'd0 : eb;
        mbe   = (eb == 8'd0) ? 24'd0 : mb;
        sbe   = r_s1.fb[31] ^ (r_s1.cmd == CMD_SUB);
        a_big = {ea, ma[22:0]} >= {ebe, mbe[22:0]};
        n_s2  = r_s1;
        case (r_s1.cmd)
            CMD_EQ: n_s2.cmp = r_s1.rf ? (r_s1.fa == r_s1.fb) : r_s1.raw_eq;
            CMD_GE: n_s2.cmp = !b_nan && !lt;
            CMD_GT: n_s2.cmp = !b_nan && gt;
            CMD_LE: n_s2.cmp = !b_nan && !gt;
            CMD_LT: n_s2.cmp = !b_nan && lt;
            CMD_ADD, CMD_SUB: begin
                n_s2.eff_sub  = r_s1.fa[31] ^ sbe;
                n_s2.spec_ovf = (eb == 8'hFF);
                if (a_big) begin
                    n_s2.sgn   = r_s1.fa[31];
                    n_s2.expo  = 10'(ea);
                    n_s2.x     = {1'b0, ma, 3'b000};
                    n_s2.xs    = {1'b0, mbe, 3'b000};
                    n_s2.shamt = ea - ebe;
                end else begin
                    n_s2.sgn   = sbe;
                    n_s2.expo  = 10'(ebe);
                    n_s2.x     = {1'b0, mbe, 3'b000};
                    n_s2.xs    = {1'b0, ma, 3'b000};
                    n_s2.shamt = ebe - ea;
                end
            end
            CMD_MUL: begin
                n_s2.sgn       = r_s1.fa[31] ^ r_s1.fb[31];
                n_s2.expo      = 10'(ea) + 10'(eb) - 10'(127);
                n_s2.wide      = ma * mb;
                n_s2.spec_ovf  = (eb == 8'hFF);
                n_s2.spec_zero = (eb == 8'd0);
            end
            CMD_DIV: begin
                n_s2.sgn       = r_s1.fa[31] ^ r_s1.fb[31];
                n_s2.expo      = 10'(ea) - 10'(eb) + 10'(127);
                n_s2.drem      = {1'b0, ma};
                n_s2.dd        = mb;
                n_s2.dq        = '0;
                // zero or denormal divisor overflows, infinity gives zero, nan overflows
                n_s2.spec_ovf  = (eb == 8'd0) || b_nan;
                n_s2.spec_zero = (eb == 8'hFF) && !b_nan;
            end
            default: n_s2.cmp = 1'b0;
        endcase
    end

    // stage 3: align the smaller addend with sticky, fold the product to working width
    always_comb begin
        logic [27:0] sh;
        logic        lost;
        sh   = r_s2.xs >> r_s2.shamt[4:0];
        lost = ((sh << r_s2.shamt[4:0]) != r_s2.xs);
        n_s3 = r_s2;
        case (r_s2.cmd)
            CMD_ADD, CMD_SUB: begin
                if (r_s2.shamt > 8'd27) begin
                    n_s3.xs = {27'd0, |r_s2.xs};
                end else begin
                    n_s3.xs = {sh[27:1], sh[0] | lost};
                end
            end
            CMD_MUL: n_s3.x = {r_s2.wide[47:21], |r_s2.wide[20:0]};
            default: n_s3.xs = r_s2.xs;
        endcase
    end

    // stage 4: magnitude add or subtract
    always_comb begin
        n_s4 = r_s3;
        if (r_s3.cmd == CMD_ADD || r_s3.cmd == CMD_SUB) begin
            n_s4.x = r_s3.eff_sub ? (r_s3.x - r_s3.xs) : (r_s3.x + r_s3.xs);
        end
    end

    assign w_dv[0] = r_v4;
    assign w_ds[0] = r_s4;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        sfa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[k]),
            .i_stage (w_ds[k]),
            .o_valid (w_dv[k+1]),
            .o_stage (w_ds[k+1])
        );
    end

    // stage 5: bring in the quotient, count leading zeros below the carry bit
    always_comb begin
        logic [27:0] xin;
        n_s5 = w_ds[DIV_STEPS];
        if (w_ds[DIV_STEPS].cmd == CMD_DIV) begin
            xin = {1'b0, w_ds[DIV_STEPS].dq, w_ds[DIV_STEPS].drem != 25'd0};
        end else begin
            xin = w_ds[DIV_STEPS].x;
        end
        n_s5.x  = xin;
        n_s5.lz = 5'd27;
        for (int i = 0; i <= 26; i++) begin
            if (xin[i]) begin
                n_s5.lz = 5'(26 - i);
            end
        end
        // exact cancellation gives +0
        if (xin == 28'd0) begin
            n_s5.spec_zero = 1'b1;
        end
    end

    // stage 6: normalize so the leading one sits at bit 26
    always_comb begin
        n_s6 = r_s5;
        if (r_s5.x[27]) begin
            n_s6.x    = {1'b0, r_s5.x[27:2], r_s5.x[1] | r_s5.x[0]};
            n_s6.expo = r_s5.expo + 10'sd1;
        end else begin
            n_s6.x    = r_s5.x << r_s5.lz;
            n_s6.expo = r_s5.expo - 10'(r_s5.lz);
        end
    end

    // stage 7: round to nearest even at 24 bits
    always_comb begin
        logic        inc;
        logic [24:0] sum;
        inc  = r_s6.x[2] & ((|r_s6.x[1:0]) | r_s6.x[3]);
        sum  = {1'b0, r_s6.x[26:3]} + 25'(inc);
        n_s7 = r_s6;
        if (sum[24]) begin
            n_s7.x    = {1'b0, sum[24:1], 3'b000};
            n_s7.expo = r_s6.expo + 10'sd1;
        end else begin
            n_s7.x    = {1'b0, sum[23:0], 3'b000};
        end
    end

    // output: pack or select per command
    always_comb begin
        logic [16:0] enc;
        n_out_code  = 16'd0;
        n_out_float = 32'd0;
        n_out_cmp   = 1'b0;
        n_out_ovf   = 1'b0;
        enc         = 17'd0;
        case (r_s7.cmd)
            CMD_PACK: begin
                enc        = f_encode(r_s7.fb[31], 10'({2'b00, r_s7.fb[30:23]}), r_s7.fb[22:0]);
                n_out_code = enc[15:0];
                n_out_ovf  = enc[16];
            end
            CMD_UNPACK: n_out_float = r_s7.fa;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (r_s7.spec_ovf) begin
                    n_out_ovf = 1'b1;
                end else if (!r_s7.spec_zero) begin
                    enc        = f_encode(r_s7.sgn, r_s7.expo, r_s7.x[25:3]);
                    n_out_code = enc[15:0];
                    n_out_ovf  = enc[16];
                end
            end
            CMD_EQ, CMD_GE, CMD_GT, CMD_LE, CMD_LT: n_out_cmp = r_s7.cmp;
            default: n_out_cmp = 1'b0;
        endcase
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= w_dv[DIV_STEPS];
            r_v6        <= r_v5;
            r_v7        <= r_v6;
            r_out_valid <= r_v7;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_s3        <= n_s3;
            r_s4        <= n_s4;
            r_s5        <= n_s5;
            r_s6        <= n_s6;
            r_s7        <= n_s7;
            r_out_code  <= n_out_code;
            r_out_float <= n_out_float;
            r_out_cmp   <= n_out_cmp;
            r_out_ovf   <= n_out_ovf;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_code   = r_out_code;
    assign o_result_float  = r_out_float;
    assign o_compare_true  = r_out_cmp;
    assign o_pack_overflow = r_out_ovf;

    // overflow always comes with a zero code
    a_ovf_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pack_overflow) |-> (o_result_code == 16'd0))
        else $error("overflow with nonzero code");

    // a comparison or an unpack result excludes a packed result
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_compare_true || o_result_float != 32'd0))
            |-> (o_result_code == 16'd0 && !o_pack_overflow))
        else $error("result fields overlap");

    // a held result stays valid and the pipeline does not drain it
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_v7)))
        else $error("held transaction lost");

endmodule

@@ design/sfa_div_step.sv @@
module sfa_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sfa_pkg::t_stage i_stage,
    output logic            o_valid,
    output sfa_pkg::t_stage o_stage
);
    import sfa_pkg::*;

    logic        r_valid;
    t_stage      r_stage;
    t_stage      n_stage;
    logic [24:0] w_diff;

    // one restoring division step: one quotient bit per stage
    always_comb begin
        n_stage = i_stage;
        w_diff  = i_stage.drem - {1'b0, i_stage.dd};
        if (i_stage.cmd == CMD_DIV) begin
            if (i_stage.drem >= {1'b0, i_stage.dd}) begin
                n_stage.dq   = {i_stage.dq[24:0], 1'b1};
                n_stage.drem = {w_diff[23:0], 1'b0};
            end else begin
                n_stage.dq   = {i_stage.dq[24:0], 1'b0};
                n_stage.drem = {i_stage.drem[23:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
